// ===== rtl/aab_pkg.sv =====
// aab_pkg: shared types, operation codes and decimal add helper for the
// accumulator/extension execute unit; no dependencies
package aab_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned FUNC_W = 5;

    localparam logic [8:0] DEC_MAX  = 9'd99;
    localparam logic [8:0] DEC_BASE = 9'd100;
    localparam logic [3:0] DEC_TEN  = 4'd10;
    localparam logic [7:0] ACC_DLY  = 8'hFF;
    localparam logic [7:0] SIGN_BIT = 8'h80;

    typedef enum logic [FUNC_W-1:0] {
        FN_LD  = 5'd0,
        FN_AND = 5'd1,
        FN_OR  = 5'd2,
        FN_XOR = 5'd3,
        FN_DAD = 5'd4,
        FN_ADD = 5'd5,
        FN_CAD = 5'd6,
        FN_LDE = 5'd7,
        FN_ANE = 5'd8,
        FN_ORE = 5'd9,
        FN_XRE = 5'd10,
        FN_DAE = 5'd11,
        FN_ADE = 5'd12,
        FN_CAE = 5'd13,
        FN_XAE = 5'd14,
        FN_CCL = 5'd15,
        FN_SCL = 5'd16,
        FN_ILD = 5'd17,
        FN_DLD = 5'd18,
        FN_SR  = 5'd19,
        FN_SRL = 5'd20,
        FN_RR  = 5'd21,
        FN_RRL = 5'd22,
        FN_SIO = 5'd23,
        FN_DLY = 5'd24,
        FN_ST  = 5'd25
    } func_t;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] ext;
        logic              carry;
        logic              ovf;
    } arch_t;

    typedef struct packed {
        arch_t             st;
        logic [DATA_W-1:0] wdata;
        logic              sout;
        logic              nonneg;
        logic              zero;
    } res_t;

    // nibble pair to value, nibbles above 9 taken as they are
    function automatic logic [7:0] digits_value(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // returns {carry, bcd sum modulo 100}
    function automatic logic [8:0] dec_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0]  sum;
        logic [8:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [7:0]  tens_x10;
        logic [3:0]  ones;
        sum = {1'b0, digits_value(a)} + {1'b0, digits_value(b)};
        if (sum >= 9'(DEC_BASE * 3)) begin
            rem = sum - 9'(DEC_BASE * 3);
        end else if (sum >= 9'(DEC_BASE * 2)) begin
            rem = sum - 9'(DEC_BASE * 2);
        end else if (sum >= DEC_BASE) begin
            rem = sum - DEC_BASE;
        end else begin
            rem = sum;
        end
        // divide by ten for values below 100
        prod     = {8'd0, rem[6:0]} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {4'd0, tens} * {4'd0, DEC_TEN};
        ones     = 4'(rem[7:0] - tens_x10);
        return {(sum > DEC_MAX), tens, ones};
    endfunction

endpackage

// ===== rtl/aab_alu.sv =====
// aab_alu: combinational execute logic for one operation
// depends on aab_pkg
module aab_alu (
    input  aab_pkg::func_t      func,
    input  logic [7:0]          operand,
    input  logic                serial_in,
    input  aab_pkg::arch_t      cur,
    output aab_pkg::res_t       res
);
    import aab_pkg::*;

    logic [7:0] add_b;
    logic [8:0] add_sum;
    logic [7:0] add_r;
    logic       add_ovf;
    logic [8:0] dec_a_sum;
    logic [7:0] dec_b;
    arch_t      nxt;
    logic [7:0] wdata;
    logic       sout;

    always_comb begin
        case (func)
            FN_ADD:  add_b = operand;
            FN_CAD:  add_b = ~operand;
            FN_ADE:  add_b = cur.ext;
            FN_CAE:  add_b = ~cur.ext;
            default: add_b = operand;
        endcase
    end

    assign add_sum = {1'b0, cur.acc} + {1'b0, add_b} + {8'd0, cur.carry};
    assign add_r   = add_sum[7:0];
    assign add_ovf = ~(cur.acc[7] ^ add_b[7]) & (cur.acc[7] ^ add_r[7]);

    assign dec_b     = (func == FN_DAE) ? cur.ext : operand;
    assign dec_a_sum = dec_add(cur.acc, dec_b);

    always_comb begin
        nxt   = cur;
        wdata = '0;
        sout  = 1'b0;
        case (func)
            FN_LD:  nxt.acc = operand;
            FN_AND: nxt.acc = cur.acc & operand;
            FN_OR:  nxt.acc = cur.acc | operand;
            FN_XOR: nxt.acc = cur.acc ^ operand;
            FN_LDE: nxt.acc = cur.ext;
            FN_ANE: nxt.acc = cur.acc & cur.ext;
            FN_ORE: nxt.acc = cur.acc | cur.ext;
            FN_XRE: nxt.acc = cur.acc ^ cur.ext;
            FN_DAD, FN_DAE: begin
                nxt.acc   = dec_a_sum[7:0];
                nxt.carry = dec_a_sum[8];
            end
            FN_ADD, FN_CAD, FN_ADE, FN_CAE: begin
                nxt.acc   = add_r;
                nxt.carry = add_sum[8];
                nxt.ovf   = add_ovf;
            end
            FN_XAE: begin
                nxt.acc = cur.ext;
                nxt.ext = cur.acc;
            end
            FN_CCL: nxt.carry = 1'b0;
            FN_SCL: nxt.carry = 1'b1;
            FN_ILD: begin
                nxt.acc = operand + 8'd1;
                wdata   = operand + 8'd1;
            end
            FN_DLD: begin
                nxt.acc = operand - 8'd1;
                wdata   = operand - 8'd1;
            end
            FN_SR:  nxt.acc = {1'b0, cur.acc[7:1]};
            FN_SRL: nxt.acc = {cur.carry, cur.acc[7:1]};
            FN_RR:  nxt.acc = {cur.acc[0], cur.acc[7:1]};
            FN_RRL: begin
                nxt.acc   = {cur.carry, cur.acc[7:1]};
                nxt.carry = cur.acc[0];
            end
            FN_SIO: begin
                sout    = cur.ext[0];
                nxt.ext = {serial_in, cur.ext[7:1]};
            end
            FN_DLY: nxt.acc = ACC_DLY;
            FN_ST:  wdata = cur.acc;
            default: begin
                nxt = cur;
            end
        endcase
    end

    assign res.st     = nxt;
    assign res.wdata  = wdata;
    assign res.sout   = sout;
    assign res.nonneg = ~|(nxt.acc & SIGN_BIT);
    assign res.zero   = ~|nxt.acc;

endmodule

// ===== rtl/accumulator_alu_bcd_binary.sv =====
// accumulator_alu_bcd_binary: top level of the accumulator/extension execute unit
// depends on aab_pkg and aab_alu
//
// usage:
// - s_ channel carries one operation per transaction: s_func, s_operand,
//   s_serial_in; m_ channel returns one result transaction per operation
// - an accepted operation sits in an input register, is executed by the
//   combinational unit once the result register can be loaded, and lands there
// - registers on the path: the input register, then the result register
// - throughput: one operation per cycle when m_ready stays high
// - the accumulator, extension, carry/link and overflow registers update
//   at the same edge that loads the result register
// - when the receiver stalls the result is held; one more operation may
//   wait in the input register, then s_ready drops until m_ready returns
// - reset (aresetn low, synchronous) empties both registers and clears the
//   accumulator, extension, carry/link and overflow
module accumulator_alu_bcd_binary (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_func,
    input  logic [7:0] s_operand,
    input  logic       s_serial_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_acc_out,
    output logic [7:0] m_ext_out,
    output logic       m_carry_link,
    output logic       m_overflow_flag,
    output logic [7:0] m_write_data,
    output logic       m_serial_out,
    output logic       m_acc_nonneg,
    output logic       m_acc_zero
);
    import aab_pkg::*;

    logic       in_valid_reg;
    func_t      in_func_reg;
    logic [7:0] in_operand_reg;
    logic       in_serial_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    arch_t      arch_reg;
    res_t       res_next;
    logic       exec;
    logic       s_take;

    aab_alu u_alu (
        .func      (in_func_reg),
        .operand   (in_operand_reg),
        .serial_in (in_serial_reg),
        .cur       (arch_reg),
        .res       (res_next)
    );

    assign exec    = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | exec;
    assign s_take  = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            arch_reg      <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (exec) begin
                in_valid_reg <= 1'b0;
            end
            if (exec) begin
                out_valid_reg <= 1'b1;
                arch_reg      <= res_next.st;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_func_reg    <= func_t'(s_func);
            in_operand_reg <= s_operand;
            in_serial_reg  <= s_serial_in;
        end
        if (exec) begin
            out_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_acc_out       = out_reg.st.acc;
    assign m_ext_out       = out_reg.st.ext;
    assign m_carry_link    = out_reg.st.carry;
    assign m_overflow_flag = out_reg.st.ovf;
    assign m_write_data    = out_reg.wdata;
    assign m_serial_out    = out_reg.sout;
    assign m_acc_nonneg    = out_reg.nonneg;
    assign m_acc_zero      = out_reg.zero;

`ifndef NO_ASSERTIONS
    // last delivered result always mirrors the architectural registers
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_acc_out == arch_reg.acc) && (m_ext_out == arch_reg.ext)
                 && (m_carry_link == arch_reg.carry)
                 && (m_overflow_flag == arch_reg.ovf))
        else $error("result register out of step with state");

    // a waiting transaction is never dropped while the output is blocked
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !exec |=> in_valid_reg && $stable(in_operand_reg))
        else $error("pending transaction lost");

    // overflow only moves on binary adds
    a_ovf_only_add: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && !(in_func_reg == FN_ADD || in_func_reg == FN_CAD
               || in_func_reg == FN_ADE || in_func_reg == FN_CAE)
        |=> $stable(arch_reg.ovf))
        else $error("overflow changed by non-add operation");

    // write-back byte only for increment, decrement and store
    a_wdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && !(in_func_reg == FN_ILD || in_func_reg == FN_DLD
               || in_func_reg == FN_ST)
        |=> m_write_data == 8'd0)
        else $error("unexpected write-back byte");
`endif

endmodule
